// ===== rtl/core/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg: decision tree classifier shared definitions
// Node entry layout, memory request bundle and id/address helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dtc_pkg;

  localparam int NODE_COUNT    = 256;
  localparam int CHANNEL_COUNT = 8;
  localparam int STEP_LIMIT    = 16;

  localparam int ID_W     = 8;
  localparam int CH_W     = 3;
  localparam int THR_W    = 9;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 64;
  localparam int ADDR_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CMP_W    = ID_W + ADDR_W + 1;
  localparam int STEP_W   = $clog2(STEP_LIMIT + 1);

  typedef logic [ID_W-1:0]   node_id_t;
  typedef logic [ADDR_W-1:0] node_addr_t;

  typedef struct packed {
    logic              is_leaf;
    logic [CH_W-1:0]   channel;
    logic [THR_W-1:0]  threshold;
    node_id_t          left_child;
    node_id_t          right_child;
  } node_t;

  typedef struct packed {
    logic     wr_en;
    node_id_t wr_id;
    node_t    wr_data;
    logic     rd_en;
    node_id_t rd_id;
  } mem_req_t;

  function automatic node_addr_t to_addr(input node_id_t id);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(id);
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic id_in_range(input node_id_t id);
    return CMP_W'(id) < CMP_W'(NODE_COUNT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtc_if.sv =====
// ----------------------------------------------------------------------------
// dtc_if: decision tree classifier channel interfaces
// Valid/ready channels for items, results and the root register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  node_index;
  logic        node_is_leaf;
  logic [2:0]  node_channel;
  logic [8:0]  node_threshold;
  logic [7:0]  left_child;
  logic [7:0]  right_child;
  logic [63:0] sample_bytes;

  modport source (
    output valid, op, node_index, node_is_leaf, node_channel, node_threshold,
           left_child, right_child, sample_bytes,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, node_is_leaf, node_channel, node_threshold,
           left_child, right_child, sample_bytes,
    output ready
  );
endinterface

interface dtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] leaf_node;
  logic       step_fault;

  modport source (output valid, leaf_node, step_fault, input ready);
  modport sink   (input valid, leaf_node, step_fault, output ready);
endinterface

interface dtc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] root_node;

  modport source (output valid, root_node, input ready);
  modport sink   (input valid, root_node, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtc_node_store.sv =====
// ----------------------------------------------------------------------------
// dtc_node_store: node table memory
// One write and one registered read per cycle; ids beyond the table read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_node_store (
  input  wire logic             clk,
  input  wire dtc_pkg::mem_req_t req,
  output dtc_pkg::node_t        rd_node
);

  dtc_pkg::node_t mem [dtc_pkg::NODE_COUNT];
  dtc_pkg::node_t rd_raw;
  logic           rd_hit;

  always_ff @(posedge clk) begin
    if (req.wr_en && dtc_pkg::id_in_range(req.wr_id)) begin
      mem[dtc_pkg::to_addr(req.wr_id)] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_raw <= mem[dtc_pkg::to_addr(req.rd_id)];
      rd_hit <= dtc_pkg::id_in_range(req.rd_id);
    end
  end

  assign rd_node = rd_hit ? rd_raw : '0;

endmodule

`default_nettype wire

// ===== rtl/core/decision_tree_classifier_top.sv =====
// ----------------------------------------------------------------------------
// decision_tree_classifier_top: binary decision tree inference
// Node table in a synchronous memory; a walk reads one node per cycle.
//
//   channel  dir  carries
//   cfg      in   root_node register write
//   req      in   op 0: node entry load, op 1: sample to classify
//   rsp      out  leaf_node, step_fault (one per classify item)
//
// A load item writes the table at the accepting edge.
// A classify item reads at most 16 nodes (the step limit) through the single
// node table read port; the result is registered.
// req stalls while a walk runs and when a finished walk finds rsp full.
// rst is synchronous; the node table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module decision_tree_classifier_top (
  input wire logic   clk,
  input wire logic   rst,
  dtc_cfg_if.sink    cfg,
  dtc_req_if.sink    req,
  dtc_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t                          state;
  state_t                          state_next;
  dtc_pkg::node_id_t               root_node;
  dtc_pkg::node_id_t               cur_id;
  logic [dtc_pkg::STEP_W-1:0]      step_cnt;
  logic [dtc_pkg::SAMPLE_W-1:0]    sample;
  logic                            out_valid;
  dtc_pkg::node_id_t               out_leaf;
  logic                            out_fault;

  dtc_pkg::mem_req_t               mem_req;
  dtc_pkg::node_t                  node;
  logic [dtc_pkg::BYTE_W-1:0]      ch_byte;
  logic                            go_left;
  dtc_pkg::node_id_t               next_id;
  logic                            last_step;
  logic                            walk_done;
  logic                            out_free;
  logic                            req_take;

  dtc_node_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_node (node)
  );

  assign cfg.ready = !rst;
  assign req.ready = !rst && (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;

  always_comb begin
    if (4'(node.channel) < 4'(dtc_pkg::CHANNEL_COUNT)) begin
      ch_byte = sample[node.channel*dtc_pkg::BYTE_W +: dtc_pkg::BYTE_W];
    end else begin
      ch_byte = '0;
    end
    go_left   = {1'b0, ch_byte} < node.threshold;
    next_id   = go_left ? node.left_child : node.right_child;
    last_step = step_cnt == dtc_pkg::STEP_W'(dtc_pkg::STEP_LIMIT - 1);
    walk_done = (state == ST_WALK) && (node.is_leaf || last_step);
    out_free  = !out_valid || rsp.ready;
  end

  always_comb begin
    mem_req.wr_en           = req_take && !req.op;
    mem_req.wr_id           = req.node_index;
    mem_req.wr_data.is_leaf     = req.node_is_leaf;
    mem_req.wr_data.channel     = req.node_channel;
    mem_req.wr_data.threshold   = req.node_threshold;
    mem_req.wr_data.left_child  = req.left_child;
    mem_req.wr_data.right_child = req.right_child;
    mem_req.rd_en = (req_take && req.op) || ((state == ST_WALK) && !walk_done);
    mem_req.rd_id = (state == ST_IDLE) ? root_node : next_id;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take && req.op) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      root_node <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        root_node <= cfg.root_node;
      end
      if (walk_done && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && req.op) begin
      cur_id   <= root_node;
      step_cnt <= '0;
      sample   <= req.sample_bytes;
    end else if ((state == ST_WALK) && !walk_done) begin
      cur_id   <= next_id;
      step_cnt <= step_cnt + 1'b1;
    end
    if (walk_done && out_free) begin
      out_leaf  <= cur_id;
      out_fault <= !node.is_leaf;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.leaf_node  = out_leaf;
  assign rsp.step_fault = out_fault;

endmodule

`default_nettype wire

// ===== rtl/core/dtc_checker.sv =====
// ----------------------------------------------------------------------------
// dtc_checker: port-level checks for the decision tree classifier
// Watches the top level's req and rsp channels; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       req_op,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_leaf_node,
  input wire logic       rsp_step_fault
);

  // held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_leaf_node)
                                   && $stable(rsp_step_fault)))
    else $error("rsp payload changed while stalled");

  // a classify item blocks req while its walk runs
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op) |=> !req_ready)
    else $error("req ready during walk");

  // a load item never makes a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !req_op && !rsp_valid) |=> !rsp_valid)
    else $error("result after load item");

  // a new result only comes out of a walk
  a_rsp_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result without walk");

endmodule

bind decision_tree_classifier_top dtc_checker u_dtc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_op         (req.op),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_leaf_node  (rsp.leaf_node),
  .rsp_step_fault (rsp.step_fault)
);

`default_nettype wire
